>>> rtl/rtspd_pkg.sv
// rtspd_pkg: constants, phase codes and shared structs of the rtsp interleaved deframer
// depends on nothing; imported by the parser, the output stage and the top level
`default_nettype none

package rtspd_pkg;

   // framing constants
   localparam logic [7:0] MARKER_BYTE      = 8'h24;
   localparam logic [7:0] CSRC_MASK        = 8'h0f;
   localparam int unsigned RTP_FIXED_HEADER = 12;
   localparam int unsigned CSRC_WORD_BYTES  = 4;

   // phase codes
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_CHANNEL = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_FIRST   = 3'd4;
   localparam logic [2:0] PH_HEADER  = 3'd5;
   localparam logic [2:0] PH_PAYLOAD = 3'd6;

   // one result of the parser, valid when a payload byte is produced
   typedef struct packed {
      logic        valid;
      logic [7:0]  payload_byte;
      logic        last_of_sample;
      logic [31:0] sample_number;
   } rtspd_result_type;

   // parser state seen by the top level
   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] bytes_left;
      logic [6:0]  header_left;
      logic [31:0] sample_counter;
   } rtspd_status_type;

endpackage

`default_nettype wire

>>> rtl/rtspd_if.sv
// rtspd_req_if / rtspd_rsp_if: valid/ready channels of the deframer
// no dependencies; used by the output stage and the top level
`default_nettype none

// raw byte channel
interface rtspd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// payload byte channel
interface rtspd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        last_of_sample;
   logic [31:0] sample_number;

   modport source (output valid, output payload_byte, output last_of_sample,
                   output sample_number, input ready);
   modport sink   (input valid, input payload_byte, input last_of_sample,
                   input sample_number, output ready);
endinterface

`default_nettype wire

>>> rtl/rtspd_parser.sv
// rtspd_parser: framing state machine and counters, one byte per step
// depends on rtspd_pkg
`default_nettype none

module rtspd_parser
   import rtspd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       in_byte,
   output rtspd_result_type      result,
   output rtspd_status_type      status
);

   localparam logic [6:0] HEADER_FIRST_LEFT = 7'(RTP_FIXED_HEADER - 1);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] packet_length_ff, packet_length_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [6:0]  header_left_ff, header_left_in;
   logic [31:0] sample_counter_ff, sample_counter_in;

   logic [15:0] bytes_dec;
   logic [6:0]  header_dec;
   logic [15:0] full_length;
   logic [3:0]  csrc_count;

   assign bytes_dec   = bytes_left_ff - 16'd1;
   assign header_dec  = header_left_ff - 7'd1;
   assign full_length = packet_length_ff | {8'h00, in_byte};
   assign csrc_count  = in_byte[3:0] & CSRC_MASK[3:0];

   // next state and result for the byte at hand
   always_comb begin
      phase_in          = phase_ff;
      packet_length_in  = packet_length_ff;
      bytes_left_in     = bytes_left_ff;
      header_left_in    = header_left_ff;
      sample_counter_in = sample_counter_ff;
      result            = '0;
      case (phase_ff)
         PH_CHANNEL: begin
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            packet_length_in = {in_byte, 8'h00};
            phase_in         = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            packet_length_in = full_length;
            bytes_left_in    = full_length;
            phase_in         = (full_length == 16'd0) ? PH_HUNT : PH_FIRST;
         end
         PH_FIRST: begin
            bytes_left_in  = bytes_dec;
            // fixed header plus four bytes per csrc, less this byte
            header_left_in = HEADER_FIRST_LEFT
                             + 7'(csrc_count * 7'(CSRC_WORD_BYTES));
            phase_in       = (bytes_dec == 16'd0) ? PH_HUNT : PH_HEADER;
         end
         PH_HEADER: begin
            bytes_left_in  = bytes_dec;
            header_left_in = header_dec;
            if (bytes_dec == 16'd0) begin
               phase_in = PH_HUNT;
            end else if (header_dec == 7'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            bytes_left_in         = bytes_dec;
            result.valid          = 1'b1;
            result.payload_byte   = in_byte;
            result.last_of_sample = (bytes_dec == 16'd0);
            result.sample_number  = sample_counter_ff;
            if (bytes_dec == 16'd0) begin
               sample_counter_in = sample_counter_ff + 32'd1;
               phase_in          = PH_HUNT;
            end
         end
         default: begin
            // hunting, and the unused code
            phase_in = (in_byte == MARKER_BYTE) ? PH_CHANNEL : PH_HUNT;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         packet_length_ff  <= '0;
         bytes_left_ff     <= '0;
         header_left_ff    <= '0;
         sample_counter_ff <= '0;
      end else if (step) begin
         phase_ff          <= phase_in;
         packet_length_ff  <= packet_length_in;
         bytes_left_ff     <= bytes_left_in;
         header_left_ff    <= header_left_in;
         sample_counter_ff <= sample_counter_in;
      end
   end

   assign status.phase          = phase_ff;
   assign status.bytes_left     = bytes_left_ff;
   assign status.header_left    = header_left_ff;
   assign status.sample_counter = sample_counter_ff;

endmodule

`default_nettype wire

>>> rtl/rtspd_out_stage.sv
// rtspd_out_stage: result register that drives the payload byte channel
// depends on rtspd_pkg and rtspd_rsp_if
`default_nettype none

module rtspd_out_stage
   import rtspd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire rtspd_result_type  result,
   output logic                   free,
   rtspd_rsp_if.source            rsp_chan
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [31:0] number_ff;

   // register can take a new value when empty or being drained
   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_chan.ready;
      if (load) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         byte_ff   <= result.payload_byte;
         last_ff   <= result.last_of_sample;
         number_ff <= result.sample_number;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.payload_byte   = byte_ff;
   assign rsp_chan.last_of_sample = last_ff;
   assign rsp_chan.sample_number  = number_ff;

endmodule

`default_nettype wire

>>> rtl/rtsp_interleaved_rtp_deframer_core.sv
// rtsp_interleaved_rtp_deframer_core: input register, parser and result register
// depends on rtspd_pkg, rtspd_if, rtspd_parser and rtspd_out_stage
//
//   channel    dir  payload                                        transaction
//   req_chan   in   in_byte[7:0]                                    valid & ready
//   rsp_chan   out  payload_byte[7:0] last_of_sample sample_number  valid & ready
//
// one byte a cycle while the result channel is not stalled: a byte enters the input
// register, the parser works on it once the result register has room, and its result, if
// any, is loaded into the result register at the same edge that steps the parser.
// synchronous reset returns the parser to hunting for the marker and empties both
// registers. a stalled result holds the input register; a new byte is taken as long
// as the input register is empty or moves on in the same cycle.
`default_nettype none

module rtsp_interleaved_rtp_deframer_core
   import rtspd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   rtspd_req_if.sink     req_chan,
   rtspd_rsp_if.source   rsp_chan
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             out_free;
   logic             step;
   rtspd_result_type result;
   rtspd_status_type status;

   // input register moves on when the result register has room
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff && !step;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.in_byte;
      end
   end

   // framing state machine
   rtspd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .result  (result),
      .status  (status)
   );

   // result register
   rtspd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // payload phase always has bytes still to come
   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      status.phase == PH_PAYLOAD |-> status.bytes_left != 16'd0)
      else $error("payload phase with no bytes left");

   // header phase always has header bytes still to come
   a_header_has_bytes: assert property (@(posedge clock) disable iff (reset)
      status.phase == PH_HEADER |-> status.header_left != 7'd0)
      else $error("header phase with no header bytes left");

   // the last byte of a sample advances the sample counter by one
   a_sample_advance: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && result.last_of_sample |=>
         status.sample_counter == $past(status.sample_counter) + 32'd1)
      else $error("sample counter did not advance after last byte");

   // a stalled result keeps the input register full
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready && in_valid_ff |-> !req_chan.ready)
      else $error("byte accepted while input register is blocked");
`endif

endmodule

`default_nettype wire
